@@ hdl/bfca_pkg.sv @@
// shared types and constants for the best-fit chunk allocator
package bfca_pkg;

   localparam int MaxChunks    = 64;
   localparam int HeaderBytes  = 32;
   localparam int AddrBits     = 20;
   localparam int SlotBits     = $clog2(MaxChunks);
   localparam int CountBits    = $clog2(MaxChunks + 1);
   localparam int TableBits    = SlotBits + 1;
   localparam int QueueDepth   = 2;

   localparam logic [1:0] StatTiny  = 2'd0;
   localparam logic [1:0] StatSmall = 2'd1;
   localparam logic [1:0] StatLarge = 2'd2;
   localparam logic [1:0] StatNone  = 2'd3;

   localparam logic [1:0] RegTinyLimit  = 2'd0;
   localparam logic [1:0] RegSmallLimit = 2'd1;
   localparam logic [1:0] RegTinyPool   = 2'd2;
   localparam logic [1:0] RegSmallPool  = 2'd3;

   localparam logic [15:0] TinyLimitRst  = 16'd128;
   localparam logic [15:0] SmallLimitRst = 16'd1024;
   localparam logic [19:0] TinyPoolRst   = 20'd65536;
   localparam logic [19:0] SmallPoolRst  = 20'd262144;

   // classified request handed from front to back
   typedef struct packed {
      logic                oversize;
      logic                pool;
      logic [AddrBits:0]   need;
   } job_type;

   // result beat
   typedef struct packed {
      logic [1:0]          status;
      logic [AddrBits-1:0] offset;
      logic [AddrBits-1:0] granted;
      logic [AddrBits-1:0] free_left;
   } rsp_type;

   function automatic logic [AddrBits-1:0] pool_size(input logic [19:0] total);
      logic [20:0] d;
      d = {1'b0, total} - 21'(HeaderBytes);
      pool_size = (total > 20'(HeaderBytes)) ? AddrBits'(d) : '0;
   endfunction

endpackage

@@ hdl/bfca_front.sv @@
// request classifier: pool choice, size rounding and a two-entry job queue
module bfca_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic [15:0]           tiny_limit,
   input  logic [15:0]           small_limit,
   output logic                  job_valid,
   input  logic                  job_ready,
   output bfca_pkg::job_type     job
);

   bfca_pkg::job_type q_ff [bfca_pkg::QueueDepth];
   logic [0:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   bfca_pkg::job_type cls;
   logic [32:0] rnd;
   logic push, pop;

   always_comb begin
      rnd = {1'b0, (req_tdata == 32'd0) ? 32'd1 : req_tdata} + 33'd15;
      cls.oversize = req_tdata > {16'd0, small_limit};
      cls.pool  = req_tdata > {16'd0, tiny_limit};
      cls.need  = {rnd[bfca_pkg::AddrBits:4], 4'd0};
   end

   assign req_tready = cnt_ff != 2'(bfca_pkg::QueueDepth);
   assign push = req_tvalid && req_tready;
   assign job_valid = cnt_ff != 2'd0;
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];
   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= cls;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(bfca_pkg::QueueDepth)) else $error("queue overflow");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count step");
   a_empty_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> wr_ff == rd_ff) else $error("pointer mismatch");

endmodule

@@ hdl/bfca_back.sv @@
// chunk table, best-fit scan, free-slot search and split write-back
module bfca_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  bfca_pkg::job_type     job,
   input  logic                  init_valid,
   input  logic                  init_pool,
   input  logic [19:0]           init_total,
   output logic                  busy,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bfca_pkg::rsp_type     out_rsp
);

   localparam int AB = bfca_pkg::AddrBits;
   localparam int SB = bfca_pkg::SlotBits;
   localparam int TB = bfca_pkg::TableBits;
   localparam int CB = bfca_pkg::CountBits;

   typedef enum logic [2:0] {IDLE, SCAN, DECIDE, WRITE, EMIT} state_type;

   logic [AB-1:0] start_mem [2*bfca_pkg::MaxChunks];
   logic [AB-1:0] bytes_mem [2*bfca_pkg::MaxChunks];
   logic [2*bfca_pkg::MaxChunks-1:0] use_ff, valid_ff;
   logic [CB-1:0] count_ff [2];
   logic [AB-1:0] free_ff [2];

   state_type st_ff;
   bfca_pkg::job_type job_ff;
   logic [SB:0] idx_ff;
   logic [SB-1:0] ridx_ff;
   logic rd_ok_ff;
   logic [AB-1:0] rd_start_ff, rd_bytes_ff;
   logic found_ff, slot_found_ff;
   logic [SB-1:0] best_ff, slot_ff;
   logic [AB-1:0] best_bytes_ff, best_start_ff;
   logic out_valid_ff;
   bfca_pkg::rsp_type res_ff, rsp_ff;

   logic [TB-1:0] raddr, best_addr, slot_addr;
   logic [AB:0] need_hdr, remain;
   logic better, avail, split;
   logic [AB-1:0] used, sub, free_cur;
   logic [2*bfca_pkg::MaxChunks-1:0] pool_mask, pool_first;

   assign raddr = {job_ff.pool, idx_ff[SB-1:0]};
   assign best_addr = {job_ff.pool, best_ff};
   assign slot_addr = {job_ff.pool, slot_ff};
   assign need_hdr = job_ff.need + (AB+1)'(bfca_pkg::HeaderBytes);
   assign avail = rd_ok_ff && valid_ff[{job_ff.pool, ridx_ff}] == 1'b1 &&
                  !use_ff[{job_ff.pool, ridx_ff}] && {1'b0, rd_bytes_ff} >= need_hdr;
   assign better = !found_ff || rd_bytes_ff < best_bytes_ff ||
                   (rd_bytes_ff == best_bytes_ff && rd_start_ff < best_start_ff);
   assign remain = {1'b0, best_bytes_ff} - job_ff.need;
   assign split = slot_found_ff && count_ff[job_ff.pool] < CB'(bfca_pkg::MaxChunks) &&
                  remain >= (AB+1)'(bfca_pkg::HeaderBytes + 16);
   assign used = split ? AB'(need_hdr) : best_bytes_ff;
   assign free_cur = free_ff[job_ff.pool];
   assign sub = free_cur >= used ? free_cur - used : '0;
   assign pool_mask = {{bfca_pkg::MaxChunks{init_pool}}, {bfca_pkg::MaxChunks{!init_pool}}};
   assign pool_first = {{(bfca_pkg::MaxChunks-1){1'b0}}, init_pool,
                        {(bfca_pkg::MaxChunks-1){1'b0}}, !init_pool};

   assign job_ready = st_ff == IDLE && !init_valid;
   assign busy = st_ff != IDLE;
   assign out_valid = out_valid_ff;
   assign out_rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE;
         out_valid_ff <= 1'b0;
         use_ff <= '0;
         valid_ff <= {{(bfca_pkg::MaxChunks-1){1'b0}}, 1'b1,
                      {(bfca_pkg::MaxChunks-1){1'b0}}, 1'b1};
         count_ff[0] <= CB'(1);
         count_ff[1] <= CB'(1);
         free_ff[0] <= bfca_pkg::pool_size(bfca_pkg::TinyPoolRst);
         free_ff[1] <= bfca_pkg::pool_size(bfca_pkg::SmallPoolRst);
         start_mem[0] <= AB'(bfca_pkg::HeaderBytes);
         bytes_mem[0] <= bfca_pkg::pool_size(bfca_pkg::TinyPoolRst);
         start_mem[bfca_pkg::MaxChunks] <= AB'(bfca_pkg::HeaderBytes);
         bytes_mem[bfca_pkg::MaxChunks] <= bfca_pkg::pool_size(bfca_pkg::SmallPoolRst);
      end else begin
         if (st_ff == EMIT && (!out_valid_ff || out_ready)) out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
         if (init_valid) begin
            use_ff <= use_ff & ~pool_mask;
            valid_ff <= (valid_ff & ~pool_mask) | pool_first;
            count_ff[init_pool] <= CB'(1);
            free_ff[init_pool] <= bfca_pkg::pool_size(init_total);
            start_mem[{init_pool, SB'(0)}] <= AB'(bfca_pkg::HeaderBytes);
            bytes_mem[{init_pool, SB'(0)}] <= bfca_pkg::pool_size(init_total);
         end
         unique case (st_ff)
            IDLE: if (job_valid && job_ready) begin
               job_ff <= job;
               idx_ff <= '0;
               rd_ok_ff <= 1'b0;
               found_ff <= 1'b0;
               slot_found_ff <= 1'b0;
               if (job.oversize) begin
                  res_ff <= '{bfca_pkg::StatLarge, '0, '0, '0};
                  st_ff <= EMIT;
               end else begin
                  st_ff <= SCAN;
               end
            end
            SCAN: begin
               rd_start_ff <= start_mem[raddr];
               rd_bytes_ff <= bytes_mem[raddr];
               ridx_ff <= idx_ff[SB-1:0];
               rd_ok_ff <= !idx_ff[SB];
               if (avail && better) begin
                  found_ff <= 1'b1;
                  best_ff <= ridx_ff;
                  best_bytes_ff <= rd_bytes_ff;
                  best_start_ff <= rd_start_ff;
               end
               if (rd_ok_ff && !valid_ff[{job_ff.pool, ridx_ff}] && !slot_found_ff) begin
                  slot_found_ff <= 1'b1;
                  slot_ff <= ridx_ff;
               end
               if (idx_ff[SB] && !rd_ok_ff) st_ff <= DECIDE;
               else if (!idx_ff[SB]) idx_ff <= idx_ff + 1'b1;
            end
            DECIDE: begin
               if (!found_ff) begin
                  res_ff <= '{bfca_pkg::StatNone, '0, '0, free_cur};
                  st_ff <= EMIT;
               end else begin
                  st_ff <= WRITE;
               end
            end
            WRITE: begin
               use_ff[best_addr] <= 1'b1;
               free_ff[job_ff.pool] <= sub;
               if (split) begin
                  valid_ff[slot_addr] <= 1'b1;
                  start_mem[slot_addr] <= best_start_ff + AB'(need_hdr);
                  bytes_mem[slot_addr] <= AB'(remain - (AB+1)'(bfca_pkg::HeaderBytes));
                  bytes_mem[best_addr] <= AB'(job_ff.need);
                  count_ff[job_ff.pool] <= count_ff[job_ff.pool] + 1'b1;
               end
               res_ff <= '{{1'b0, job_ff.pool}, best_start_ff,
                           split ? AB'(job_ff.need) : best_bytes_ff, sub};
               st_ff <= EMIT;
            end
            EMIT: if (!out_valid_ff || out_ready) begin
               rsp_ff <= res_ff;
               st_ff <= IDLE;
            end
            default: st_ff <= IDLE;
         endcase
      end
   end

   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      st_ff == EMIT && (!out_valid_ff || out_ready) |=> out_valid_ff && st_ff == IDLE)
      else $error("emit lost");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(rsp_ff))
      else $error("result dropped");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CB'(bfca_pkg::MaxChunks) && count_ff[1] <= CB'(bfca_pkg::MaxChunks))
      else $error("chunk count overflow");

endmodule

@@ hdl/best_fit_chunk_allocator.sv @@
// best-fit chunk allocator top level with configuration registers
// Takes one request beat on req_ (tdata = request_bytes) and returns one
// response beat on rsp_ with status, payload offset, granted size and the
// free bytes left in the chosen pool. Requests above small_limit come back
// as passed on without a table scan. Others go to the tiny or small pool,
// where the back end scans all 64 table slots through the chunk memory
// read port, one slot per cycle, then writes the chunk and any split back.
// The back end takes a new request only after the response of the last
// one has gone into the output register. The front end classifies
// requests into a two-entry queue, so up to two more beats are taken
// while one is worked on. The response sits in an output register; while
// rsp_tready is low the back end finishes its request, then holds and the
// queue fills, then req_tready drops.
// Reset restores the register defaults and sets each pool to one free
// chunk. Writing a pool size register re-initializes that pool at once.
module best_fit_chunk_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // request_bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // status, payload_offset, granted_bytes, pool_free_left
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   logic [15:0] tiny_limit_ff, small_limit_ff;
   logic job_valid, job_ready, busy, init_valid, init_pool;
   bfca_pkg::job_type job;
   bfca_pkg::rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         tiny_limit_ff <= bfca_pkg::TinyLimitRst;
         small_limit_ff <= bfca_pkg::SmallLimitRst;
      end else if (csr_we) begin
         if (csr_index == bfca_pkg::RegTinyLimit) tiny_limit_ff <= csr_wdata[15:0];
         if (csr_index == bfca_pkg::RegSmallLimit) small_limit_ff <= csr_wdata[15:0];
      end
   end

   assign init_valid = csr_we && (csr_index == bfca_pkg::RegTinyPool ||
                                  csr_index == bfca_pkg::RegSmallPool);
   assign init_pool = csr_index == bfca_pkg::RegSmallPool;

   bfca_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .tiny_limit(tiny_limit_ff), .small_limit(small_limit_ff),
      .job_valid, .job_ready, .job
   );

   bfca_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .init_valid, .init_pool, .init_total(csr_wdata), .busy,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tdata = {2'b00, rsp.free_left, rsp.granted, rsp.offset, rsp.status};

   a_init_idle: assert property (@(posedge clock) disable iff (reset)
      init_valid |-> !busy || csr_index == bfca_pkg::RegTinyPool ||
                     csr_index == bfca_pkg::RegSmallPool) else $error("bad init");
   a_no_take_init: assert property (@(posedge clock) disable iff (reset)
      init_valid |-> !job_ready) else $error("job taken during init");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("beat withdrawn");

endmodule
